### src/sws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_pkg: shared types and constants
// Payload structs, register indexes and statistic mode codes for the
// sliding window statistics block.
// ----------------------------------------------------------------------------
package sws_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int STAT_BITS      = 41;
   localparam int WLEN_BITS      = 9;
   localparam int MODE_BITS      = 3;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 9;
   localparam int MAX_WINDOW_DEF = 256;
   localparam int FRAC_BITS_DEF  = 16;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LEN = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STAT_MODE  = 1'b1;

   // statistic modes
   localparam logic [MODE_BITS-1:0] MODE_SUM   = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_MAX   = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_MIN   = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_COUNT = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_DEV   = 3'd4;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          sample_null;
      logic                          series_start;
   } req_type;

   typedef struct packed {
      logic signed [STAT_BITS-1:0] stat_value;
      logic                        stat_null;
   } rsp_type;

endpackage

### src/sws_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_queue: two-entry job queue
// Decouples the front (sample intake) from the back (window evaluation).
// ----------------------------------------------------------------------------
module sws_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] din,
   input  logic         pop,
   output logic [W-1:0] dout,
   output logic         full,
   output logic         empty,
   output logic [1:0]   count
);

   logic [W-1:0] slot_ff [2];
   logic         wp_ff;
   logic         rp_ff;
   logic [1:0]   cnt_ff;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign dout  = slot_ff[rp_ff];
   assign count = cnt_ff;

   // payload storage
   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wp_ff] <= din;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push && !full) wp_ff <= ~wp_ff;
         if (pop && !empty) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, (push && !full)} - {1'b0, (pop && !empty)};
      end
   end

endmodule

### src/sws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_front: sample intake
// Tracks the history slot and series fill, works out the window length for
// each sample and hands a job to the queue.
// ----------------------------------------------------------------------------
module sws_front #(
   parameter int MAX_WINDOW = 256,
   parameter int JW         = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  sws_pkg::req_type                    req_data,
   output logic                                req_full,
   input  logic [sws_pkg::WLEN_BITS-1:0]       window_len,
   input  logic                                q_full,
   output logic                                job_push,
   output logic [JW-1:0]                       job_data
);
   import sws_pkg::*;

   localparam int AW = $clog2(MAX_WINDOW);
   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam int LW = (CW > WLEN_BITS) ? CW : WLEN_BITS;

   typedef struct packed {
      logic [CW-1:0]                 n;
      logic [AW-1:0]                 slot;
      logic                          is_null;
      logic signed [SAMPLE_BITS-1:0] sample;
   } job_type;

   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] fill_base;
   logic [LW-1:0] wlen_ext, fill_ext;
   logic          accept;
   job_type       job;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;
   assign job_push = accept;

   // series fill and window length for this beat
   always_comb begin
      fill_base = req_data.series_start ? '0 : fill_ff;
      fill_in   = (fill_base == CW'(MAX_WINDOW)) ? fill_base : fill_base + 1'b1;
      pos_in    = (pos_ff == AW'(MAX_WINDOW - 1)) ? '0 : pos_ff + 1'b1;
      wlen_ext  = LW'(window_len);
      fill_ext  = LW'(fill_in);
      job.n       = (wlen_ext < fill_ext) ? CW'(wlen_ext) : fill_in;
      job.slot    = pos_ff;
      job.is_null = req_data.sample_null;
      job.sample  = req_data.sample;
   end

   assign job_data = JW'(job);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         fill_ff <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         fill_ff <= fill_in;
      end
   end

endmodule

### src/sws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_back: window evaluation
// Stores the sample, scans the window one entry a cycle, then for deviation
// runs a shared 16x48 multiply, a bit-serial square root and divide.
// ----------------------------------------------------------------------------
module sws_back #(
   parameter int MAX_WINDOW = 256,
   parameter int FRAC_BITS  = 16,
   parameter int JW         = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               job_valid,
   input  logic [JW-1:0]                      job_data,
   output logic                               job_pop,
   input  logic [sws_pkg::MODE_BITS-1:0]      stat_mode,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output sws_pkg::rsp_type                   rsp_data
);
   import sws_pkg::*;

   localparam int AW   = $clog2(MAX_WINDOW);
   localparam int CW   = $clog2(MAX_WINDOW + 1);
   localparam int SB   = SAMPLE_BITS;
   localparam int SUMW = SB + AW + 1;
   localparam int QW   = 32 + FRAC_BITS;
   localparam int RW   = QW + 3;
   localparam int ITW  = $clog2(QW + 1);

   typedef struct packed {
      logic [CW-1:0]        n;
      logic [AW-1:0]        slot;
      logic                 is_null;
      logic signed [SB-1:0] sample;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_MUL_CQ, ST_MUL_S2, ST_SQRT, ST_DIV, ST_RESULT
   } state_type;

   job_type   job;
   state_type state_ff;

   // history memory and read port
   logic [SB:0]   hist [MAX_WINDOW];
   logic [SB:0]   rd_q_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] rd_addr_ff;
   logic [CW-1:0] iss_ff;

   // scan pipeline
   logic                 v1_ff, v2_ff, v3_ff;
   logic [SB-1:0]        abs_ff;
   logic [2*SB-1:0]      prod_ff;
   logic signed [SUMW-1:0] sum_ff;
   logic [63:0]          sq_ff;
   logic [CW-1:0]        cnt_ff;
   logic signed [SB-1:0] mx_ff, mn_ff;
   logic                 started_ff;

   // multiply, root and divide
   logic [63:0]     ma_ff, mp_ff, cq_ff, dd_ff;
   logic [47:0]     mb_ff;
   logic [1:0]      mk_ff;
   logic [RW-1:0]   sr_ff;
   logic [QW-1:0]   rq_ff, dn_ff;
   logic [CW-1:0]   drem_ff;
   logic [ITW-1:0]  it_ff;

   logic            rsp_valid_ff;
   rsp_type         rsp_ff;

   // combinational helpers
   logic signed [SB-1:0]   s_cur;
   logic                   n_cur;
   logic [SUMW-1:0]        sum_abs;
   logic [63:0]            pp, mp_in, dval;
   logic [RW-1:0]          r2, rt;
   logic [QW-1:0]          rq_in;
   logic [CW:0]            dr2;
   logic [CW-1:0]          drem_in;
   logic [QW-1:0]          dn_in;
   logic                   scan_done;
   logic [63:0]            sum64, mx64, mn64, dev64;
   rsp_type                res;

   assign job     = job_type'(job_data);
   assign job_pop = (state_ff == ST_IDLE) && job_valid;
   assign mem_we  = job_pop;
   assign mem_re  = (state_ff == ST_SCAN) && (iss_ff != '0);

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // history memory
   always_ff @(posedge clock) begin
      if (mem_we) hist[job.slot] <= {job.is_null, job.sample};
      if (mem_re) rd_q_ff <= hist[rd_addr_ff];
   end

   always_comb begin
      s_cur   = rd_q_ff[SB-1:0];
      n_cur   = rd_q_ff[SB];
      sum_abs = sum_ff[SUMW-1] ? SUMW'(-sum_ff) : SUMW'(sum_ff);
      // one 16x48 partial product per cycle
      pp      = 64'(ma_ff[{mk_ff, 4'b0000} +: 16] * mb_ff);
      mp_in   = mp_ff + (pp << {mk_ff, 4'b0000});
      dval    = (cq_ff > mp_in) ? cq_ff - mp_in : 64'd0;
      // root step
      r2      = {sr_ff[RW-3:0], dd_ff[63:62]};
      rt      = RW'({rq_ff, 2'b01});
      rq_in   = (r2 >= rt) ? {rq_ff[QW-2:0], 1'b1} : {rq_ff[QW-2:0], 1'b0};
      // divide step
      dr2     = {drem_ff, dn_ff[QW-1]};
      drem_in = (dr2 >= {1'b0, cnt_ff}) ? CW'(dr2 - {1'b0, cnt_ff}) : CW'(dr2);
      dn_in   = {dn_ff[QW-2:0], (dr2 >= {1'b0, cnt_ff})};
      scan_done = (iss_ff == '0) && !v1_ff && !v2_ff && !v3_ff;
   end

   // result selection
   always_comb begin
      sum64 = {{(64-SUMW){sum_ff[SUMW-1]}}, sum_ff};
      mx64  = {{(64-SB){mx_ff[SB-1]}}, mx_ff};
      mn64  = {{(64-SB){mn_ff[SB-1]}}, mn_ff};
      dev64 = 64'(dn_ff);
      res.stat_value = '0;
      res.stat_null  = 1'b0;
      case (stat_mode)
         MODE_SUM: begin
            res.stat_value = sum64[STAT_BITS-1:0];
         end
         MODE_MAX: begin
            if (started_ff) res.stat_value = mx64[STAT_BITS-1:0];
            else res.stat_null = 1'b1;
         end
         MODE_MIN: begin
            if (started_ff) res.stat_value = mn64[STAT_BITS-1:0];
            else res.stat_null = 1'b1;
         end
         MODE_COUNT: begin
            res.stat_value = STAT_BITS'(cnt_ff);
         end
         MODE_DEV: begin
            if (cnt_ff == '0) res.stat_null = 1'b1;
            else res.stat_value = dev64[STAT_BITS-1:0];
         end
         default: begin
            res.stat_null = 1'b1;
         end
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         iss_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
      end else begin
         // result popped; the result state reloads it on its own
         if (rsp_pop && rsp_valid_ff && state_ff != ST_RESULT) rsp_valid_ff <= 1'b0;

         // scan pipeline: read, accumulate and take magnitude, square, add square
         v1_ff <= mem_re;
         if (mem_re) begin
            rd_addr_ff <= (rd_addr_ff == '0) ? AW'(MAX_WINDOW - 1) : rd_addr_ff - 1'b1;
            iss_ff     <= iss_ff - 1'b1;
         end
         v2_ff <= v1_ff && !n_cur;
         if (v1_ff && !n_cur) begin
            sum_ff <= sum_ff + {{(SUMW-SB){s_cur[SB-1]}}, s_cur};
            cnt_ff <= cnt_ff + 1'b1;
            abs_ff <= s_cur[SB-1] ? SB'(-s_cur) : SB'(s_cur);
            if (!started_ff || s_cur > mx_ff) mx_ff <= s_cur;
            if (!started_ff || s_cur < mn_ff) mn_ff <= s_cur;
            started_ff <= 1'b1;
         end
         v3_ff   <= v2_ff;
         prod_ff <= abs_ff * abs_ff;
         if (v3_ff) sq_ff <= sq_ff + 64'(prod_ff);

         case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  rd_addr_ff <= job.slot;
                  iss_ff     <= job.n;
                  sum_ff     <= '0;
                  sq_ff      <= '0;
                  cnt_ff     <= '0;
                  started_ff <= 1'b0;
                  state_ff   <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_done) begin
                  if (stat_mode == MODE_DEV && cnt_ff != '0) begin
                     ma_ff    <= sq_ff;
                     mb_ff    <= 48'(cnt_ff);
                     mp_ff    <= '0;
                     mk_ff    <= 2'd0;
                     state_ff <= ST_MUL_CQ;
                  end else begin
                     state_ff <= ST_RESULT;
                  end
               end
            end
            ST_MUL_CQ: begin
               mp_ff <= (mk_ff == 2'd3) ? 64'd0 : mp_in;
               mk_ff <= mk_ff + 1'b1;
               if (mk_ff == 2'd3) begin
                  cq_ff    <= mp_in;
                  ma_ff    <= 64'(sum_abs);
                  mb_ff    <= 48'(sum_abs);
                  state_ff <= ST_MUL_S2;
               end
            end
            ST_MUL_S2: begin
               mp_ff <= mp_in;
               mk_ff <= mk_ff + 1'b1;
               if (mk_ff == 2'd3) begin
                  if (dval == 64'd0) begin
                     dn_ff    <= '0;
                     state_ff <= ST_RESULT;
                  end else begin
                     dd_ff    <= dval;
                     sr_ff    <= '0;
                     rq_ff    <= '0;
                     it_ff    <= ITW'(QW);
                     state_ff <= ST_SQRT;
                  end
               end
            end
            ST_SQRT: begin
               sr_ff <= (r2 >= rt) ? r2 - rt : r2;
               rq_ff <= rq_in;
               dd_ff <= {dd_ff[61:0], 2'b00};
               it_ff <= (it_ff == ITW'(1)) ? ITW'(QW) : it_ff - 1'b1;
               if (it_ff == ITW'(1)) begin
                  dn_ff    <= rq_in;
                  drem_ff  <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               drem_ff <= drem_in;
               dn_ff   <= dn_in;
               it_ff   <= it_ff - 1'b1;
               if (it_ff == ITW'(1)) state_ff <= ST_RESULT;
            end
            ST_RESULT: begin
               if (!rsp_valid_ff || rsp_pop) begin
                  rsp_ff       <= res;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### src/sliding_window_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_statistics: windowed sum, max, min, count and deviation
// Front takes samples into a two-entry job queue; back evaluates the window
// ending at each sample and holds the result in an output register.
// ----------------------------------------------------------------------------
//  channel  ports                         beat taken when
//  input    req_push req_full req_data    req_push & !req_full
//  result   rsp_empty rsp_pop rsp_data    rsp_pop & !rsp_empty
//  config   csr_write csr_index csr_data  csr_write
//
//  Sum, max, min and count scan n history entries, where n is the window
//  length capped at the series fill; deviation adds the multiply and the
//  bit-serial root and divide. The scan reads one history entry a cycle.
//  Reset clears all control state; history needs no clearing pass.
//  Input fills the queue up to full while a result waits to be popped.
// ----------------------------------------------------------------------------
module sliding_window_statistics #(
   parameter int MAX_WINDOW = sws_pkg::MAX_WINDOW_DEF,
   parameter int FRAC_BITS  = sws_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  sws_pkg::req_type                     req_data,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output sws_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write,
   input  logic [sws_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sws_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import sws_pkg::*;

   localparam int AW = $clog2(MAX_WINDOW);
   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam int JW = CW + AW + 1 + SAMPLE_BITS;

   logic [WLEN_BITS-1:0] window_len_ff;
   logic [MODE_BITS-1:0] stat_mode_ff;
   logic                 job_push, job_pop, q_full, q_empty;
   logic [JW-1:0]        job_in, job_out;
   logic [1:0]           q_count;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WLEN_BITS'(1);
         stat_mode_ff  <= MODE_SUM;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WINDOW_LEN: window_len_ff <= csr_data[WLEN_BITS-1:0];
            CSR_STAT_MODE:  stat_mode_ff  <= csr_data[MODE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   sws_front #(
      .MAX_WINDOW (MAX_WINDOW),
      .JW         (JW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .window_len (window_len_ff),
      .q_full     (q_full),
      .job_push   (job_push),
      .job_data   (job_in)
   );

   sws_queue #(
      .W (JW)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .din   (job_in),
      .pop   (job_pop),
      .dout  (job_out),
      .full  (q_full),
      .empty (q_empty),
      .count (q_count)
   );

   sws_back #(
      .MAX_WINDOW (MAX_WINDOW),
      .FRAC_BITS  (FRAC_BITS),
      .JW         (JW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!q_empty),
      .job_data  (job_out),
      .job_pop   (job_pop),
      .stat_mode (stat_mode_ff),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // reset leaves no result and no queued job
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (rsp_empty && q_count == 2'd0))
      else $error("result or job present after reset");

   // an accepted sample shows up in the queue
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> (q_count != 2'd0))
      else $error("accepted sample missing from queue");

   // back end never takes a job from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (q_count != 2'd0))
      else $error("job taken from empty queue");
`endif

endmodule
